/* sv/pchw_pkg.sv */
// Package: shared widths, event codes, status codes and control types.
`timescale 1ns / 1ps
package pchw_pkg;

  localparam int unsigned COORD_W  = 15;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned HOLD_W   = 8;
  localparam int unsigned WHEEL_W  = 16;
  localparam int unsigned ACCUM_W  = 32;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned CDATA_W  = 15;

  localparam logic [COORD_W-1:0] WIDTH_RST  = 15'd320;
  localparam logic [COORD_W-1:0] HEIGHT_RST = 15'd240;
  localparam logic [HOLD_W-1:0]  HOLD_RST   = 8'd2;

  localparam logic signed [ACCUM_W-1:0] ACCUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ACCUM_W-1:0] ACCUM_MIN = 32'sh8000_0000;
  localparam logic signed [WHEEL_W-1:0] STEP_MAX  = 16'sh7FFF;
  localparam logic signed [WHEEL_W-1:0] STEP_MIN  = 16'sh8000;

  typedef enum logic [2:0] {
    MODE_MOVE      = 3'd0,
    MODE_DOWN      = 3'd1,
    MODE_UP        = 3'd2,
    MODE_WHEEL     = 3'd3,
    MODE_READ_PTR  = 3'd4,
    MODE_PEEK_PTR  = 3'd5,
    MODE_READ_WHL  = 3'd6,
    MODE_CLEAR     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_REJECT   = 2'd1,
    STAT_IGNORED  = 2'd2,
    STAT_RSVD     = 2'd3
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_HOLD   = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  // Wheel accumulator controls, at most one asserted per cycle.
  typedef struct packed {
    logic add;
    logic take;
    logic clr;
  } wheel_ctl_t;

endpackage

/* sv/pchw_if.sv */
// Interfaces: event channel, result channel and register write channel.
`timescale 1ns / 1ps
interface pchw_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [2:0]                             mode;
  logic [pchw_pkg::POS_W-1:0]             pos_x;
  logic [pchw_pkg::POS_W-1:0]             pos_y;
  logic [2:0]                             button_mask;
  logic signed [pchw_pkg::WHEEL_W-1:0]    wheel_delta;

  modport source (output valid, mode, pos_x, pos_y, button_mask, wheel_delta,
                  input ready);
  modport sink   (input valid, mode, pos_x, pos_y, button_mask, wheel_delta,
                  output ready);
endinterface

interface pchw_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [pchw_pkg::COORD_W-1:0]           out_x;
  logic [pchw_pkg::COORD_W-1:0]           out_y;
  logic                                   out_pressed;
  logic signed [pchw_pkg::WHEEL_W-1:0]    wheel_out;
  logic [1:0]                             status;

  modport source (output valid, out_x, out_y, out_pressed, wheel_out, status,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_pressed, wheel_out, status,
                  output ready);
endinterface

interface pchw_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [pchw_pkg::CIDX_W-1:0]            index;
  logic [pchw_pkg::CDATA_W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/pchw_wheel.sv */
// Saturating signed wheel accumulator with clamped take-out.
`timescale 1ns / 1ps
module pchw_wheel (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pchw_pkg::wheel_ctl_t                 ctl,
  input  logic signed [pchw_pkg::WHEEL_W-1:0]  delta,
  output logic signed [pchw_pkg::WHEEL_W-1:0]  take_val
);

  logic signed [pchw_pkg::ACCUM_W-1:0] accum_r;
  logic signed [pchw_pkg::ACCUM_W-1:0] accum_nxt;
  logic signed [pchw_pkg::ACCUM_W:0]   sum;
  logic signed [pchw_pkg::ACCUM_W-1:0] sum_sat;
  logic                                fits16;

  assign sum = {accum_r[pchw_pkg::ACCUM_W-1], accum_r}
             + {{(pchw_pkg::ACCUM_W+1-pchw_pkg::WHEEL_W){delta[pchw_pkg::WHEEL_W-1]}},
                delta};

  always_comb begin
    if (sum[pchw_pkg::ACCUM_W] != sum[pchw_pkg::ACCUM_W-1]) begin
      sum_sat = sum[pchw_pkg::ACCUM_W] ? pchw_pkg::ACCUM_MIN : pchw_pkg::ACCUM_MAX;
    end else begin
      sum_sat = sum[pchw_pkg::ACCUM_W-1:0];
    end
  end

  // Fits in 16 bits when all upper bits match the sign.
  assign fits16 = (&accum_r[pchw_pkg::ACCUM_W-1:pchw_pkg::WHEEL_W-1])
               || ~(|accum_r[pchw_pkg::ACCUM_W-1:pchw_pkg::WHEEL_W-1]);

  always_comb begin
    if (fits16) begin
      take_val = accum_r[pchw_pkg::WHEEL_W-1:0];
    end else if (accum_r[pchw_pkg::ACCUM_W-1]) begin
      take_val = pchw_pkg::STEP_MIN;
    end else begin
      take_val = pchw_pkg::STEP_MAX;
    end
  end

  always_comb begin
    accum_nxt = accum_r;
    if (ctl.clr) begin
      accum_nxt = '0;
    end else if (ctl.add) begin
      accum_nxt = sum_sat;
    end else if (ctl.take) begin
      accum_nxt = accum_r
                - {{(pchw_pkg::ACCUM_W-pchw_pkg::WHEEL_W){take_val[pchw_pkg::WHEEL_W-1]}},
                   take_val};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else begin
      accum_r <= accum_nxt;
    end
  end

endmodule

/* sv/pointer_click_hold_wheel_accumulator_top.sv */
// Top level: pointer event filter with click hold and wheel accumulator.
// A result word appears on the output register in the cycle after its event
// word is accepted. Throughput: one word per cycle; the input is ready
// whenever the output register is empty or being drained in the same cycle.
// Reset (synchronous, rst_n low): all pointer and wheel state clears, the
// output register empties, registers return to width 320, height 240, hold 2.
`timescale 1ns / 1ps
module pointer_click_hold_wheel_accumulator_top (
  input  logic    clk,
  input  logic    rst_n,
  pchw_in_if.sink    in_ch,
  pchw_out_if.source out_ch,
  pchw_cfg_if.sink   cfg_ch
);

  // Configuration registers
  logic [pchw_pkg::COORD_W-1:0] width_r;
  logic [pchw_pkg::COORD_W-1:0] height_r;
  logic [pchw_pkg::HOLD_W-1:0]  hold_reads_r;

  // Pointer state
  logic [pchw_pkg::COORD_W-1:0] cur_x_r, cur_x_nxt;
  logic [pchw_pkg::COORD_W-1:0] cur_y_r, cur_y_nxt;
  logic                         left_down_r, left_down_nxt;
  logic                         pend_r, pend_nxt;
  logic [pchw_pkg::HOLD_W-1:0]  hold_r, hold_nxt;
  logic [pchw_pkg::COORD_W-1:0] frz_x_r, frz_x_nxt;
  logic [pchw_pkg::COORD_W-1:0] frz_y_r, frz_y_nxt;

  // Output register
  logic                                out_valid_r;
  logic [pchw_pkg::COORD_W-1:0]        ox_r, ox_nxt;
  logic [pchw_pkg::COORD_W-1:0]        oy_r, oy_nxt;
  logic                                op_r, op_nxt;
  logic signed [pchw_pkg::WHEEL_W-1:0] wout_r, wout_nxt;
  pchw_pkg::status_t                   st_r, st_nxt;

  logic                                accept;
  logic                                in_range;
  logic                                left;
  pchw_pkg::mode_t                     mode;
  pchw_pkg::wheel_ctl_t                wctl;
  logic signed [pchw_pkg::WHEEL_W-1:0] wheel_take;

  // Output register is free when empty or drained this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign mode     = pchw_pkg::mode_t'(in_ch.mode);
  assign left     = in_ch.button_mask[0];
  assign in_range = (in_ch.pos_x < {1'b0, width_r})
                 && (in_ch.pos_y < {1'b0, height_r});

  pchw_wheel u_wheel (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (wctl),
    .delta    (in_ch.wheel_delta),
    .take_val (wheel_take)
  );

  // Single pass: compute next state and the result word from the accepted
  // event word and current state.
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    left_down_nxt = left_down_r;
    pend_nxt      = pend_r;
    hold_nxt      = hold_r;
    frz_x_nxt     = frz_x_r;
    frz_y_nxt     = frz_y_r;
    ox_nxt        = '0;
    oy_nxt        = '0;
    op_nxt        = 1'b0;
    wout_nxt      = '0;
    st_nxt        = pchw_pkg::STAT_OK;
    wctl          = '0;

    if (accept) begin
      case (mode)
        pchw_pkg::MODE_MOVE, pchw_pkg::MODE_DOWN,
        pchw_pkg::MODE_UP, pchw_pkg::MODE_WHEEL: begin
          if (!in_range) begin
            st_nxt = pchw_pkg::STAT_REJECT;
          end else begin
            cur_x_nxt = in_ch.pos_x[pchw_pkg::COORD_W-1:0];
            cur_y_nxt = in_ch.pos_y[pchw_pkg::COORD_W-1:0];
            if (in_ch.button_mask[2:1] != 2'b00) begin
              st_nxt = pchw_pkg::STAT_IGNORED;
            end
            if (mode == pchw_pkg::MODE_WHEEL) begin
              wctl.add = 1'b1;
            end
            if (mode == pchw_pkg::MODE_DOWN) begin
              // Left press cancels any pending release.
              if (left) begin
                left_down_nxt = 1'b1;
                pend_nxt      = 1'b0;
                hold_nxt      = '0;
              end
            end else if (mode == pchw_pkg::MODE_UP) begin
              if (left) begin
                left_down_nxt = 1'b1;
              end else if (left_down_r) begin
                // Start (or restart) the hold and freeze the click point.
                pend_nxt  = 1'b1;
                hold_nxt  = hold_reads_r;
                frz_x_nxt = in_ch.pos_x[pchw_pkg::COORD_W-1:0];
                frz_y_nxt = in_ch.pos_y[pchw_pkg::COORD_W-1:0];
              end
            end else if (mode == pchw_pkg::MODE_MOVE) begin
              // Keep left_down while a release is pending.
              if (!pend_r) begin
                left_down_nxt = left;
              end
            end
          end
        end
        pchw_pkg::MODE_READ_PTR: begin
          if (pend_r) begin
            if (hold_r == '0) begin
              // Hold used up: finish the release, report live position.
              left_down_nxt = 1'b0;
              pend_nxt      = 1'b0;
              ox_nxt        = cur_x_r;
              oy_nxt        = cur_y_r;
            end else begin
              hold_nxt = hold_r - pchw_pkg::HOLD_W'(1);
              ox_nxt   = frz_x_r;
              oy_nxt   = frz_y_r;
              op_nxt   = 1'b1;
            end
          end else begin
            ox_nxt = cur_x_r;
            oy_nxt = cur_y_r;
            op_nxt = left_down_r;
          end
        end
        pchw_pkg::MODE_PEEK_PTR: begin
          // Same view as a read, except once the hold is used up; hold does not advance.
          if (pend_r) begin
            ox_nxt = frz_x_r;
            oy_nxt = frz_y_r;
            op_nxt = 1'b1;
          end else begin
            ox_nxt = cur_x_r;
            oy_nxt = cur_y_r;
            op_nxt = left_down_r;
          end
        end
        pchw_pkg::MODE_READ_WHL: begin
          wctl.take = 1'b1;
          wout_nxt  = wheel_take;
        end
        pchw_pkg::MODE_CLEAR: begin
          // Frozen point and registers survive a clear.
          cur_x_nxt     = '0;
          cur_y_nxt     = '0;
          left_down_nxt = 1'b0;
          pend_nxt      = 1'b0;
          hold_nxt      = '0;
          wctl.clr      = 1'b1;
        end
        default: begin
          st_nxt = pchw_pkg::STAT_OK;
        end
      endcase
    end
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      left_down_r <= 1'b0;
      pend_r      <= 1'b0;
      hold_r      <= '0;
      frz_x_r     <= '0;
      frz_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      left_down_r <= left_down_nxt;
      pend_r      <= pend_nxt;
      hold_r      <= hold_nxt;
      frz_x_r     <= frz_x_nxt;
      frz_y_r     <= frz_y_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      op_r   <= op_nxt;
      wout_r <= wout_nxt;
      st_r   <= st_nxt;
    end
  end

  // Register writes; a zero size is dropped, unknown index ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= pchw_pkg::WIDTH_RST;
      height_r     <= pchw_pkg::HEIGHT_RST;
      hold_reads_r <= pchw_pkg::HOLD_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (pchw_pkg::reg_idx_t'(cfg_ch.index))
        pchw_pkg::REG_WIDTH: begin
          if (cfg_ch.data != '0) begin
            width_r <= cfg_ch.data;
          end
        end
        pchw_pkg::REG_HEIGHT: begin
          if (cfg_ch.data != '0) begin
            height_r <= cfg_ch.data;
          end
        end
        pchw_pkg::REG_HOLD: begin
          hold_reads_r <= cfg_ch.data[pchw_pkg::HOLD_W-1:0];
        end
        default: begin
          hold_reads_r <= hold_reads_r;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_x       = ox_r;
  assign out_ch.out_y       = oy_r;
  assign out_ch.out_pressed = op_r;
  assign out_ch.wheel_out   = wout_r;
  assign out_ch.status      = st_r;

endmodule

/* tb/pointer_click_hold_wheel_accumulator_top_test.sv */
// Testbench: pointer event filter with click hold and wheel accumulator, checked per result word.
`timescale 1ns / 1ps
module pointer_click_hold_wheel_accumulator_top_test;
  import pchw_pkg::*;

  // Longest stretch with no word moving on any channel before the run is called stuck.
  // The worst correct case is the long output hold-off below, well under this.
  localparam int IDLE_LIMIT   = 2000;
  localparam int CHOKE_CYCLES = 150;
  // Full-scale wheel words per burst, enough that several reads are needed to empty it.
  localparam int BURST_WORDS  = 40;
  localparam int PROBE_COUNT  = 27;

  typedef struct packed {
    mode_t                     mode;
    logic [POS_W-1:0]          x;
    logic [POS_W-1:0]          y;
    logic [2:0]                btn;
    logic signed [WHEEL_W-1:0] delta;
  } ptr_event_t;

  typedef struct packed {
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic                      pressed;
    logic signed [WHEEL_W-1:0] wheel;
    status_t                   status;
  } ptr_report_t;

  // One directed probe: the event, and a hand-written report where it is obvious.
  typedef struct packed {
    ptr_event_t  ev;
    logic        typed;
    ptr_report_t rep;
  } probe_row_t;

  localparam ptr_report_t IDLE_OK  = '{15'd0, 15'd0, 1'b0, 16'sd0, STAT_OK};
  localparam ptr_report_t REJECTED = '{15'd0, 15'd0, 1'b0, 16'sd0, STAT_REJECT};

  // Directed probes, run with the reset register values (320 x 240, hold of 2 reads).
  localparam probe_row_t PROBES [PROBE_COUNT] = '{
    // fresh state: nothing pressed, no wheel steps
    '{'{MODE_READ_PTR, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b1, IDLE_OK},
    '{'{MODE_READ_WHL, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b1, IDLE_OK},
    // far corner of the display still inside, one past either edge rejected
    '{'{MODE_MOVE, 16'd319, 16'd239, 3'd0, 16'sd0}, 1'b1, IDLE_OK},
    '{'{MODE_MOVE, 16'd320, 16'd0, 3'd0, 16'sd0}, 1'b1, REJECTED},
    '{'{MODE_MOVE, 16'd0, 16'd240, 3'd0, 16'sd0}, 1'b1, REJECTED},
    // rejected wheel word must not add to the accumulator
    '{'{MODE_WHEEL, 16'hFFFF, 16'hFFFF, 3'd7, STEP_MAX}, 1'b1, REJECTED},
    '{'{MODE_PEEK_PTR, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b1,
      '{15'd319, 15'd239, 1'b0, 16'sd0, STAT_OK}},
    // click, release, then walk the hold; peek leaves the hold alone,
    // a move during the hold only moves the pointer
    '{'{MODE_DOWN, 16'd10, 16'd20, 3'd1, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_PEEK_PTR, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_UP, 16'd30, 16'd40, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_READ_PTR, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_PEEK_PTR, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_MOVE, 16'd50, 16'd60, 3'd7, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_READ_PTR, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_READ_PTR, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    // up with left still held keeps the button down
    '{'{MODE_DOWN, 16'd1, 16'd1, 3'd1, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_UP, 16'd2, 16'd2, 3'd3, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_PEEK_PTR, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    // second release during a pending one restarts the hold at the new point
    '{'{MODE_UP, 16'd3, 16'd3, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_UP, 16'd4, 16'd4, 3'd4, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_READ_PTR, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    // down without left only moves; clear; up with nothing down only moves
    '{'{MODE_DOWN, 16'd5, 16'd5, 3'd6, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_CLEAR, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    '{'{MODE_UP, 16'd6, 16'd6, 3'd0, 16'sd0}, 1'b0, IDLE_OK},
    // both wheel extremes, then hand out what is left
    '{'{MODE_WHEEL, 16'd0, 16'd0, 3'd0, STEP_MAX}, 1'b0, IDLE_OK},
    '{'{MODE_WHEEL, 16'd0, 16'd0, 3'd2, STEP_MIN}, 1'b0, IDLE_OK},
    '{'{MODE_READ_WHL, 16'd0, 16'd0, 3'd0, 16'sd0}, 1'b0, IDLE_OK}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pchw_in_if  in_ch ();
  pchw_out_if out_ch ();
  pchw_cfg_if cfg_ch ();

  // Pointer tracker state and its copy of the registers.
  logic [COORD_W-1:0]        cur_x, cur_y, frozen_x, frozen_y;
  logic [COORD_W-1:0]        disp_width, disp_height;
  logic                      left_down, release_pending;
  logic [HOLD_W-1:0]         hold_left, hold_reads;
  logic signed [ACCUM_W-1:0] wheel_sum;

  // Reports owed by the block, oldest first.
  ptr_report_t awaited_reports [$];

  int words_sent      = 0;
  int reports_checked = 0;
  int mismatches      = 0;
  int settings_used   = 0;
  int idle_cycles     = 0;
  bit gaps_on         = 1'b1;
  bit choke_req       = 1'b0;

  pointer_click_hold_wheel_accumulator_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Advance the tracker by one accepted event word and return the report it owes.
  function automatic ptr_report_t track_pointer(input ptr_event_t ev);
    ptr_report_t               rep;
    logic signed [ACCUM_W:0]   sum;
    logic signed [ACCUM_W-1:0] taken;
    rep = '0;
    rep.status = STAT_OK;
    case (ev.mode)
      MODE_MOVE, MODE_DOWN, MODE_UP, MODE_WHEEL: begin
        if (ev.x >= POS_W'(disp_width) || ev.y >= POS_W'(disp_height)) begin
          rep.status = STAT_REJECT;
        end else begin
          cur_x = ev.x[COORD_W-1:0];
          cur_y = ev.y[COORD_W-1:0];
          if (ev.btn[2:1] != 2'b00) rep.status = STAT_IGNORED;
          case (ev.mode)
            MODE_WHEEL: begin
              // widen by one bit so the sum cannot wrap, then pin to the 32-bit range
              sum = wheel_sum + $signed(ev.delta);
              if (sum > ACCUM_MAX) wheel_sum = ACCUM_MAX;
              else if (sum < ACCUM_MIN) wheel_sum = ACCUM_MIN;
              else wheel_sum = sum[ACCUM_W-1:0];
            end
            MODE_DOWN: begin
              if (ev.btn[0]) begin
                left_down       = 1'b1;
                release_pending = 1'b0;
                hold_left       = '0;
              end
            end
            MODE_UP: begin
              if (ev.btn[0]) begin
                left_down = 1'b1;
              end else if (left_down) begin
                release_pending = 1'b1;
                hold_left       = hold_reads;
                frozen_x        = cur_x;
                frozen_y        = cur_y;
              end
            end
            default: begin
              // a move during a pending release leaves the button state alone
              if (!release_pending) left_down = ev.btn[0];
            end
          endcase
        end
      end
      MODE_READ_PTR, MODE_PEEK_PTR: begin
        // only a real read spends the hold; once it is spent the release completes
        if (ev.mode == MODE_READ_PTR && release_pending) begin
          if (hold_left == '0) begin
            left_down       = 1'b0;
            release_pending = 1'b0;
          end else begin
            hold_left = hold_left - HOLD_W'(1);
          end
        end
        if (release_pending) begin
          rep.x       = frozen_x;
          rep.y       = frozen_y;
          rep.pressed = 1'b1;
        end else begin
          rep.x       = cur_x;
          rep.y       = cur_y;
          rep.pressed = left_down;
        end
      end
      MODE_READ_WHL: begin
        // hand out at most one 16-bit step count, keep the rest
        if (wheel_sum > STEP_MAX) taken = STEP_MAX;
        else if (wheel_sum < STEP_MIN) taken = STEP_MIN;
        else taken = wheel_sum;
        wheel_sum = wheel_sum - taken;
        rep.wheel = taken[WHEEL_W-1:0];
      end
      default: begin
        // clear keeps the frozen click point and the registers
        cur_x           = '0;
        cur_y           = '0;
        left_down       = 1'b0;
        release_pending = 1'b0;
        hold_left       = '0;
        wheel_sum       = '0;
      end
    endcase
    return rep;
  endfunction

  // Coordinate inside the display, or with wild set, often on or past its edge.
  function automatic logic [POS_W-1:0] pick_coord(input logic [COORD_W-1:0] limit,
                                                  input bit wild);
    if (wild) begin
      case ($urandom_range(0, 5))
        0: return POS_W'(limit);
        1: return POS_W'(limit) - POS_W'(1);
        2: return POS_W'($urandom_range(0, 65535));
        3: return '0;
        default: ;
      endcase
    end
    return POS_W'($urandom_range(0, int'(limit) - 1));
  endfunction

  function automatic logic signed [WHEEL_W-1:0] pick_delta();
    case ($urandom_range(0, 5))
      0: return STEP_MAX;
      1: return STEP_MIN;
      2: return WHEEL_W'($urandom_range(0, 8)) - 16'sd4;
      default: return WHEEL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic ptr_event_t compose(input mode_t m, input logic [2:0] btn,
                                         input bit wild);
    ptr_event_t ev;
    ev.mode  = m;
    ev.x     = pick_coord(disp_width, wild);
    ev.y     = pick_coord(disp_height, wild);
    ev.btn   = btn;
    // carry a delta on every word so its bits toggle even where it is unused
    ev.delta = pick_delta();
    return ev;
  endfunction

  // Offer one event word and hold it until the block takes it; then owe its report.
  task automatic send_word(input ptr_event_t ev, input logic typed = 1'b0,
                           input ptr_report_t typed_rep = '0);
    int          gap;
    ptr_report_t rep;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode        = ev.mode;
    in_ch.pos_x       = ev.x;
    in_ch.pos_y       = ev.y;
    in_ch.button_mask = ev.btn;
    in_ch.wheel_delta = ev.delta;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    rep = track_pointer(ev);
    awaited_reports.push_back(typed ? typed_rep : rep);
    words_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Stop offering and wait until every owed report has come back.
  task automatic drain_reports();
    release_input();
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [CDATA_W-1:0] data);
    drain_reports();
    // every event word yields a report, so a few cycles past the last one is idle
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_WIDTH:  if (data != '0) disp_width = data;
      REG_HEIGHT: if (data != '0) disp_height = data;
      REG_HOLD:   hold_reads = data[HOLD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Full click, then enough reads to run the hold out and complete the release.
  task automatic click_and_drain();
    int reads;
    send_word(compose(MODE_DOWN, 3'b001, 1'b0));
    send_word(compose(MODE_UP, 3'b000, 1'b0));
    reads = int'(hold_reads) + 2;
    repeat (reads) send_word(compose(MODE_READ_PTR, 3'b000, 1'b0));
  endtask

  // Mostly well-formed click gestures with random content, the rest noise.
  task automatic random_phase(input int n);
    int         stop_at;
    int         steps;
    logic [2:0] extra;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 29) == 0) gaps_on = !gaps_on;
      // now and then let everything drain before going on
      if ($urandom_range(0, 99) == 0) drain_reports();
      if ($urandom_range(0, 9) < 7) begin
        extra = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(1, 3)) << 1 : 3'b000;
        send_word(compose(MODE_DOWN, extra | 3'b001, $urandom_range(0, 9) == 0));
        steps = $urandom_range(0, 3);
        repeat (steps) begin
          case ($urandom_range(0, 3))
            0: send_word(compose(MODE_PEEK_PTR, 3'($urandom_range(0, 7)), 1'b0));
            1: send_word(compose(MODE_WHEEL, extra | 3'b001, 1'b0));
            2: send_word(compose(MODE_READ_PTR, 3'($urandom_range(0, 7)), 1'b0));
            default: send_word(compose(MODE_MOVE, extra | 3'($urandom_range(0, 9) != 0),
                                       $urandom_range(0, 7) == 0));
          endcase
        end
        send_word(compose(MODE_UP, extra | 3'($urandom_range(0, 6) == 0),
                          $urandom_range(0, 9) == 0));
        steps = $urandom_range(0, 5);
        repeat (steps) begin
          case ($urandom_range(0, 5))
            0: send_word(compose(MODE_PEEK_PTR, 3'($urandom_range(0, 7)), 1'b0));
            1: send_word(compose(MODE_READ_WHL, 3'($urandom_range(0, 7)), 1'b0));
            2: send_word(compose(MODE_MOVE, 3'($urandom_range(0, 7)), 1'b1));
            default: send_word(compose(MODE_READ_PTR, 3'($urandom_range(0, 7)), 1'b0));
          endcase
        end
      end else begin
        send_word(compose(mode_t'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 1'b1));
      end
    end
  endtask

  task automatic run_setting(input logic [CDATA_W-1:0] width, input logic [CDATA_W-1:0] height,
                             input logic [CDATA_W-1:0] hold, input int n);
    write_register(REG_WIDTH, width);
    write_register(REG_HEIGHT, height);
    write_register(REG_HOLD, hold);
    settings_used++;
    click_and_drain();
    random_phase(n);
  endtask

  // Compare one field of a result word against the owed report.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: stall at random, once hold off for a long stretch, check every word.
  initial begin : report_sink
    int          stall;
    ptr_report_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = gaps_on ? $urandom_range(0, 9) : 0;
      if (choke_req) begin
        // hold off long enough that the output register fills and the input stalls
        stall     = CHOKE_CYCLES;
        choke_req = 1'b0;
      end
      @(negedge clk);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (awaited_reports.size() == 0) begin
        $display("%0t: result word with nothing owed, x=%0d y=%0d pressed=%0b wheel=%0d st=%0d",
                 $time, out_ch.out_x, out_ch.out_y, out_ch.out_pressed, out_ch.wheel_out,
                 out_ch.status);
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("out_x", want.x, out_ch.out_x);
        check_field("out_y", want.y, out_ch.out_y);
        check_field("out_pressed", want.pressed, out_ch.out_pressed);
        check_field("wheel_out", want.wheel, out_ch.wheel_out);
        check_field("status", want.status, out_ch.status);
      end
      reports_checked++;
    end
  end

  // Watchdog: count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    // drive every input to a known value from time zero
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_MOVE;
    in_ch.pos_x       = '0;
    in_ch.pos_y       = '0;
    in_ch.button_mask = '0;
    in_ch.wheel_delta = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_WIDTH;
    cfg_ch.data       = '0;

    disp_width      = WIDTH_RST;
    disp_height     = HEIGHT_RST;
    hold_reads      = HOLD_RST;
    cur_x           = '0;
    cur_y           = '0;
    frozen_x        = '0;
    frozen_y        = '0;
    left_down       = 1'b0;
    release_pending = 1'b0;
    hold_left       = '0;
    wheel_sum       = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed probes under the reset register values.
    settings_used++;
    for (int i = 0; i < PROBE_COUNT; i++) begin
      send_word(PROBES[i].ev, PROBES[i].typed, PROBES[i].rep);
    end

    // Write outside the register list: must change nothing.
    write_register(REG_NONE, '1);
    // Zero display sizes are dropped; hold data is cut to 8 bits (255).
    run_setting('0, '0, '1, 200);
    // Widest display, no hold at all; hold off the result side early in this one.
    choke_req = 1'b1;
    run_setting('1, '1, '0, 200);
    // Single-pixel display, one-read hold.
    run_setting(15'd1, 15'd1, 15'd1, 200);
    run_setting(15'($urandom_range(2, 2000)), 15'($urandom_range(2, 2000)),
                15'($urandom_range(2, 9)), 200);

    // Full-scale wheel bursts in both directions, back to back with no stalls on either side.
    drain_reports();
    gaps_on = 1'b0;
    send_word(ptr_event_t'{MODE_CLEAR, 16'd0, 16'd0, 3'd0, 16'sd0});
    repeat (BURST_WORDS) send_word(ptr_event_t'{MODE_WHEEL, 16'd0, 16'd0, 3'd0, STEP_MAX});
    repeat (3) send_word(ptr_event_t'{MODE_READ_WHL, 16'd0, 16'd0, 3'd0, 16'sd0});
    send_word(ptr_event_t'{MODE_CLEAR, 16'd0, 16'd0, 3'd0, 16'sd0});
    repeat (BURST_WORDS) send_word(ptr_event_t'{MODE_WHEEL, 16'd0, 16'd0, 3'd0, STEP_MIN});
    repeat (3) send_word(ptr_event_t'{MODE_READ_WHL, 16'd0, 16'd0, 3'd0, 16'sd0});

    // Let the last report come back, then watch a few more cycles for strays.
    drain_reports();
    repeat (5) @(posedge clk);

    $display("Run covered %0d event words under %0d register settings, %0d reports checked",
             words_sent, settings_used, reports_checked);
    $display("Included click holds up to 255 reads and clamped wheel hand-out, %0d errors",
             mismatches);
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/pchw_pkg.sv
sv/pchw_if.sv
sv/pchw_wheel.sv
sv/pointer_click_hold_wheel_accumulator_top.sv
tb/pointer_click_hold_wheel_accumulator_top_test.sv
